// ----- design/priority_round_robin_scheduler_assert.svh -----
// Assertion macros for the priority round-robin scheduler.
// Used by the top level; expects clk and rst_n in scope.
`ifndef PRIORITY_ROUND_ROBIN_SCHEDULER_ASSERT_SVH
`define PRIORITY_ROUND_ROBIN_SCHEDULER_ASSERT_SVH

// same-cycle implication
`define PRRS_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("prrs assertion failed");

// next-cycle implication
`define PRRS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("prrs assertion failed");

`endif

// ----- design/prrs_pkg.sv -----
// Shared types and constants for the priority round-robin scheduler.
// No dependencies.
package prrs_pkg;

  localparam int MAX_TASKS = 16;
  localparam int IDX_W     = $clog2(MAX_TASKS);
  localparam int CNT_W     = $clog2(MAX_TASKS + 1);

  typedef enum logic [1:0] {
    FN_LOAD  = 2'd0,
    FN_SLICE = 2'd1,
    FN_CLEAR = 2'd2
  } prrs_func_t;

  typedef enum logic [2:0] {
    ST_LOADED  = 3'd0,
    ST_FULL    = 3'd1,
    ST_GRANTED = 3'd2,
    ST_NONE    = 3'd3,
    ST_CLEARED = 3'd4
  } prrs_status_t;

  typedef struct packed {
    logic [7:0]  id;
    logic [7:0]  prio;
    logic [15:0] rem;
  } prrs_entry_t;

  // broadcast to every cell of the chain
  typedef struct packed {
    logic        ins_en;
    prrs_entry_t ins_entry;
    logic [15:0] dec_amount;
  } prrs_cell_cmd_t;

endpackage

// ----- design/prrs_if.sv -----
// Valid/ready channel interfaces for the scheduler's task and slice beats.
// Depends on nothing.
interface prrs_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  func;
  logic [7:0]  task_id;
  logic [7:0]  task_priority;
  logic [15:0] task_burst;

  modport source (output valid, func, task_id, task_priority, task_burst, input ready);
  modport sink   (input valid, func, task_id, task_priority, task_burst, output ready);
endinterface

interface prrs_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [7:0]  slice_id;
  logic [7:0]  slice_priority;
  logic [15:0] run_time;
  logic        task_finished;

  modport source (output valid, status, slice_id, slice_priority, run_time, task_finished,
                  input ready);
  modport sink   (input valid, status, slice_id, slice_priority, run_time, task_finished,
                  output ready);
endinterface

// ----- design/prrs_cell.sv -----
// One table slot of the sorted task chain: holds an entry, shifts right on insert.
// Depends on prrs_pkg.
module prrs_cell import prrs_pkg::*; (
  input  logic           clk,
  input  prrs_cell_cmd_t cmd,
  input  logic           valid,
  input  logic           at_tail,
  input  logic           dec_sel,
  input  logic           left_open,
  input  prrs_entry_t    left_entry,
  output logic           open,
  output prrs_entry_t    entry
);

  prrs_entry_t entry_r, entry_nxt;

  // open: this slot and everything right of it moves for the new task
  assign open  = cmd.ins_en && (valid ? (entry_r.prio > cmd.ins_entry.prio) : at_tail);
  assign entry = entry_r;

  always_comb begin
    entry_nxt = entry_r;
    if (left_open) begin
      entry_nxt = left_entry;
    end else if (open) begin
      entry_nxt = cmd.ins_entry;
    end else if (dec_sel) begin
      entry_nxt.rem = entry_r.rem - cmd.dec_amount;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

endmodule

// ----- design/priority_round_robin_scheduler.sv -----
// Top level of the priority round-robin scheduler: controller plus chain of cells.
// Depends on prrs_pkg, prrs_if, prrs_cell and priority_round_robin_scheduler_assert.svh.
//
//  port     | dir | beat contents
//  ---------+-----+---------------------------------------------------
//  in_ch    | in  | func, task_id, task_priority, task_burst
//  out_ch   | out | status, slice_id, slice_priority, run_time, task_finished
//  cfg_*    | in  | quantum write (cfg_we, cfg_wdata)
//
// Load, clear, unused codes and a slice on an empty table finish in the accept cycle;
// the result shows next cycle.
// A slice request on a non-empty table walks the chain one slot per cycle from the
// scan position until it finds a task with time left or has tried every slot.
// Reset clears count and scan position and sets quantum to 4; table slots are not cleared.
// The result register frees the input side; a stalled result holds a finished search.
`include "priority_round_robin_scheduler_assert.svh"

module priority_round_robin_scheduler import prrs_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  prrs_in_if.sink     in_ch,
  prrs_out_if.source  out_ch,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_SCAN = 2'b10
  } state_t;

  state_t             state_r, state_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic [IDX_W-1:0]   scan_pos_r, scan_pos_nxt;
  logic [IDX_W-1:0]   idx_r, idx_nxt;
  logic [IDX_W-1:0]   steps_r, steps_nxt;
  logic [15:0]        quantum_r;

  logic               out_valid_r, out_valid_nxt;
  prrs_status_t       out_status_r, out_status_nxt;
  logic [7:0]         out_id_r, out_id_nxt;
  logic [7:0]         out_prio_r, out_prio_nxt;
  logic [15:0]        out_run_r, out_run_nxt;
  logic               out_fin_r, out_fin_nxt;

  prrs_cell_cmd_t     cmd;
  prrs_entry_t        entries [MAX_TASKS];
  logic [MAX_TASKS-1:0] open_v;
  logic               grant;

  prrs_entry_t        cur;
  logic [15:0]        q_eff;
  logic [15:0]        run;
  logic               out_free;
  logic               accept;
  logic               last_idx;
  logic               last_step;

  // chain
  for (genvar i = 0; i < MAX_TASKS; i++) begin : g_cell
    prrs_cell u_cell (
      .clk        (clk),
      .cmd        (cmd),
      .valid      (CNT_W'(i) < count_r),
      .at_tail    (CNT_W'(i) == count_r),
      .dec_sel    (grant && (idx_r == IDX_W'(i))),
      .left_open  ((i == 0) ? 1'b0 : open_v[(i == 0) ? 0 : i - 1]),
      .left_entry (entries[(i == 0) ? 0 : i - 1]),
      .open       (open_v[i]),
      .entry      (entries[i])
    );
  end

  assign cur       = entries[idx_r];
  assign q_eff     = (quantum_r == 16'd0) ? 16'd1 : quantum_r;
  assign run       = (cur.rem < q_eff) ? cur.rem : q_eff;
  assign out_free  = !out_valid_r || out_ch.ready;
  assign in_ch.ready = (state_r == S_IDLE) && out_free;
  assign accept    = in_ch.valid && in_ch.ready;
  assign last_idx  = ({1'b0, idx_r} == (count_r - CNT_W'(1)));
  assign last_step = ({1'b0, steps_r} == (count_r - CNT_W'(1)));

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    scan_pos_nxt   = scan_pos_r;
    idx_nxt        = idx_r;
    steps_nxt      = steps_r;
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    out_status_nxt = out_status_r;
    out_id_nxt     = out_id_r;
    out_prio_nxt   = out_prio_r;
    out_run_nxt    = out_run_r;
    out_fin_nxt    = out_fin_r;
    grant          = 1'b0;
    cmd.ins_en     = 1'b0;
    cmd.ins_entry  = '{id: in_ch.task_id, prio: in_ch.task_priority, rem: in_ch.task_burst};
    cmd.dec_amount = run;

    if (accept) begin
      out_valid_nxt = 1'b1;
      out_id_nxt    = 8'd0;
      out_prio_nxt  = 8'd0;
      out_run_nxt   = 16'd0;
      out_fin_nxt   = 1'b0;
      unique case (in_ch.func)
        FN_LOAD: begin
          if (count_r == CNT_W'(MAX_TASKS)) begin
            out_status_nxt = ST_FULL;
          end else begin
            cmd.ins_en     = 1'b1;
            count_nxt      = count_r + CNT_W'(1);
            scan_pos_nxt   = '0;
            out_status_nxt = ST_LOADED;
          end
        end
        FN_SLICE: begin
          out_status_nxt = ST_NONE;
          if (count_r != '0) begin
            out_valid_nxt = 1'b0;
            state_nxt     = S_SCAN;
            idx_nxt       = scan_pos_r;
            steps_nxt     = '0;
          end
        end
        FN_CLEAR: begin
          count_nxt      = '0;
          scan_pos_nxt   = '0;
          out_status_nxt = ST_CLEARED;
        end
        default: begin
          out_status_nxt = ST_NONE;
        end
      endcase
    end else if (state_r == S_SCAN) begin
      if (cur.rem != 16'd0) begin
        if (out_free) begin
          grant          = 1'b1;
          state_nxt      = S_IDLE;
          scan_pos_nxt   = last_idx ? '0 : idx_r + IDX_W'(1);
          out_valid_nxt  = 1'b1;
          out_status_nxt = ST_GRANTED;
          out_id_nxt     = cur.id;
          out_prio_nxt   = cur.prio;
          out_run_nxt    = run;
          out_fin_nxt    = (cur.rem == run);
        end
      end else if (last_step) begin
        if (out_free) begin
          state_nxt      = S_IDLE;
          out_valid_nxt  = 1'b1;
          out_status_nxt = ST_NONE;
          out_id_nxt     = 8'd0;
          out_prio_nxt   = 8'd0;
          out_run_nxt    = 16'd0;
          out_fin_nxt    = 1'b0;
        end
      end else begin
        idx_nxt   = last_idx ? '0 : idx_r + IDX_W'(1);
        steps_nxt = steps_r + IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      scan_pos_r  <= '0;
      idx_r       <= '0;
      steps_r     <= '0;
      quantum_r   <= 16'd4;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      scan_pos_r  <= scan_pos_nxt;
      idx_r       <= idx_nxt;
      steps_r     <= steps_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        quantum_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    out_status_r <= out_status_nxt;
    out_id_r     <= out_id_nxt;
    out_prio_r   <= out_prio_nxt;
    out_run_r    <= out_run_nxt;
    out_fin_r    <= out_fin_nxt;
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.status         = out_status_r;
  assign out_ch.slice_id       = out_id_r;
  assign out_ch.slice_priority = out_prio_r;
  assign out_ch.run_time       = out_run_r;
  assign out_ch.task_finished  = out_fin_r;

  `PRRS_ASSERT_NOW(a_count_bound, 1'b1, count_r <= CNT_W'(MAX_TASKS))
  `PRRS_ASSERT_NOW(a_scan_in_table, count_r != '0, {1'b0, scan_pos_r} < count_r)
  `PRRS_ASSERT_NOW(a_grant_nonzero, out_valid_r && out_status_r == ST_GRANTED, out_run_r != 16'd0)
  `PRRS_ASSERT_NEXT(a_grant_leaves_scan, state_r == S_SCAN && grant, state_r == S_IDLE && out_valid_r)

endmodule

// ----- test/prrs_reply_monitor.sv -----
`timescale 1ns / 100ps
// Reply monitor for the priority round-robin scheduler: predicts each reply from
// the accepted task beats and quantum writes, and compares the reply beats in order.
// Depends on prrs_pkg and the channel interfaces in prrs_if.
module prrs_reply_monitor import prrs_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  prrs_in_if         in_ch,
  prrs_out_if        out_ch,
  input  logic       cfg_we,
  input  logic [15:0] cfg_wdata,
  output int         mismatch_count,
  output int         outstanding
);

  typedef struct {
    prrs_status_t status;
    logic [7:0]   id;
    logic [7:0]   prio;
    logic [15:0]  run;
    logic         fin;
  } reply_t;

  logic [7:0]  task_ids   [MAX_TASKS];
  logic [7:0]  task_prios [MAX_TASKS];
  logic [15:0] task_rem   [MAX_TASKS];
  int          n_tasks;
  int          scan_pos;
  logic [15:0] slice_quantum;
  reply_t      expected_replies[$];

  task automatic schedule_step(input logic [1:0] fn, input logic [7:0] id,
                               input logic [7:0] prio, input logic [15:0] burst,
                               output reply_t r);
    int          pos;
    int          idx;
    int          steps;
    logic [15:0] q;
    logic [15:0] run;
    r = '{status: ST_NONE, id: 8'd0, prio: 8'd0, run: 16'd0, fin: 1'b0};
    case (fn)
      FN_LOAD: begin
        if (n_tasks >= MAX_TASKS) begin
          r.status = ST_FULL;
        end else begin
          pos = n_tasks;
          while (pos > 0 && task_prios[pos-1] > prio) pos--;
          for (int k = n_tasks; k > pos; k--) begin
            task_ids[k]   = task_ids[k-1];
            task_prios[k] = task_prios[k-1];
            task_rem[k]   = task_rem[k-1];
          end
          task_ids[pos]   = id;
          task_prios[pos] = prio;
          task_rem[pos]   = burst;
          n_tasks++;
          scan_pos = 0;
          r.status = ST_LOADED;
        end
      end
      FN_SLICE: begin
        if (n_tasks != 0) begin
          idx   = scan_pos % n_tasks;
          steps = 0;
          while (steps < n_tasks && task_rem[idx] == 16'd0) begin
            idx = (idx + 1) % n_tasks;
            steps++;
          end
          if (steps < n_tasks) begin
            q   = (slice_quantum == 16'd0) ? 16'd1 : slice_quantum;
            run = (task_rem[idx] < q) ? task_rem[idx] : q;
            task_rem[idx] = task_rem[idx] - run;
            scan_pos = (idx + 1) % n_tasks;
            r = '{status: ST_GRANTED, id: task_ids[idx], prio: task_prios[idx],
                  run: run, fin: (task_rem[idx] == 16'd0)};
          end
        end
      end
      FN_CLEAR: begin
        n_tasks  = 0;
        scan_pos = 0;
        r.status = ST_CLEARED;
      end
      default: ;
    endcase
  endtask

  always @(posedge clk) begin
    reply_t want;
    if (!rst_n) begin
      n_tasks        = 0;
      scan_pos       = 0;
      slice_quantum  = 16'd4;
      mismatch_count = 0;
      expected_replies.delete();
    end else begin
      if (cfg_we) slice_quantum = cfg_wdata;
      if (out_ch.valid && out_ch.ready) begin
        if (expected_replies.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("unexpected reply beat: status=%0d id=%0d prio=%0d run=%0d fin=%0d",
                     out_ch.status, out_ch.slice_id, out_ch.slice_priority,
                     out_ch.run_time, out_ch.task_finished);
        end else begin
          want = expected_replies.pop_front();
          if (out_ch.status !== want.status || out_ch.slice_id !== want.id ||
              out_ch.slice_priority !== want.prio || out_ch.run_time !== want.run ||
              out_ch.task_finished !== want.fin) begin
            mismatch_count++;
            if (mismatch_count <= 10) begin
              $display("reply mismatch: expected status=%0d id=%0d prio=%0d run=%0d fin=%0d",
                       want.status, want.id, want.prio, want.run, want.fin);
              $display("                got      status=%0d id=%0d prio=%0d run=%0d fin=%0d",
                       out_ch.status, out_ch.slice_id, out_ch.slice_priority,
                       out_ch.run_time, out_ch.task_finished);
            end
          end
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        schedule_step(in_ch.func, in_ch.task_id, in_ch.task_priority, in_ch.task_burst, want);
        expected_replies.push_back(want);
      end
    end
    outstanding <= expected_replies.size();
  end

endmodule

// ----- test/tb_priority_round_robin_scheduler.sv -----
`timescale 1ns / 100ps
// Testbench top for the priority round-robin scheduler: clock, reset, task beats,
// quantum writes and reply back-pressure. Depends on prrs_pkg, prrs_if, the block
// and prrs_reply_monitor, which does all prediction and checking.
module tb_priority_round_robin_scheduler;
  import prrs_pkg::*;

  localparam int          DRAIN_CYCLES = 24;
  localparam int          STALL_LIMIT  = 4000;
  localparam int          HOLD_CYCLES  = 200;
  localparam int          N_PHASES     = 10;
  localparam int          PHASE_BEATS  = 76;
  localparam logic [1:0]  FN_UNUSED    = 2'd3;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [15:0] cfg_wdata;
  int          mismatch_count;
  int          outstanding;
  int          beats_sent;
  bit          calm;
  bit          hold_req;

  prrs_in_if  in_ch ();
  prrs_out_if out_ch ();

  priority_round_robin_scheduler dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  prrs_reply_monitor monitor (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_ch          (in_ch),
    .out_ch         (out_ch),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .mismatch_count (mismatch_count),
    .outstanding    (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_ch.ready <= 1'b0;
        hold_req = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end else begin
        out_ch.ready <= calm || ($urandom_range(99) >= 34);
      end
    end
  end

  initial begin
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("tb_priority_round_robin_scheduler: FAIL");
    $finish;
  end

  function automatic logic [7:0] pick_prio();
    return ($urandom_range(99) < 50) ? 8'($urandom_range(0, 3)) : 8'($urandom_range(0, 255));
  endfunction

  function automatic logic [15:0] pick_burst();
    int r;
    r = $urandom_range(99);
    if (r < 10) return 16'd0;
    if (r < 70) return 16'($urandom_range(1, 12));
    if (r < 85) return 16'($urandom_range(13, 300));
    return 16'($urandom_range(0, 65535));
  endfunction

  // call at a falling edge; returns at the falling edge after acceptance
  task automatic send_beat(input logic [1:0] fn, input logic [7:0] id,
                           input logic [7:0] prio, input logic [15:0] burst);
    while (!calm && $urandom_range(99) < 34) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid         <= 1'b1;
    in_ch.func          <= fn;
    in_ch.task_id       <= id;
    in_ch.task_priority <= prio;
    in_ch.task_burst    <= burst;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    @(negedge clk);
    beats_sent++;
  endtask

  task automatic request_slice();
    send_beat(FN_SLICE, 8'($urandom), 8'($urandom), 16'($urandom));
  endtask

  task automatic pause_input();
    in_ch.valid <= 1'b0;
    @(negedge clk);
    while (outstanding != 0) @(negedge clk);
  endtask

  task automatic write_quantum(input logic [15:0] value);
    pause_input();
    repeat (DRAIN_CYCLES) @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic run_sequence();
    int n_loads;
    int n_slices;
    int mid_load;
    if ($urandom_range(99) < 12) begin
      repeat ($urandom_range(1, 4))
        send_beat(2'($urandom_range(0, 3)), 8'($urandom), 8'($urandom), 16'($urandom));
    end else begin
      if ($urandom_range(99) < 70)
        send_beat(FN_CLEAR, 8'($urandom), 8'($urandom), 16'($urandom));
      n_loads = ($urandom_range(99) < 15) ? $urandom_range(14, 20) : $urandom_range(1, 8);
      repeat (n_loads) send_beat(FN_LOAD, 8'($urandom), pick_prio(), pick_burst());
      n_slices = $urandom_range(1, 3 * n_loads + 6);
      mid_load = $urandom_range(0, 2 * n_slices);
      for (int s = 0; s < n_slices; s++) begin
        if (s == mid_load) send_beat(FN_LOAD, 8'($urandom), pick_prio(), pick_burst());
        request_slice();
      end
    end
  endtask

  initial begin
    int          phase_start;
    logic [15:0] q;
    rst_n               = 1'b0;
    cfg_we              = 1'b0;
    cfg_wdata           = 16'd0;
    in_ch.valid         = 1'b0;
    in_ch.func          = FN_LOAD;
    in_ch.task_id       = 8'd0;
    in_ch.task_priority = 8'd0;
    in_ch.task_burst    = 16'd0;
    calm                = 1'b0;
    hold_req            = 1'b0;
    beats_sent          = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed, reset quantum
    request_slice();
    send_beat(FN_UNUSED, 8'hFF, 8'hFF, 16'hFFFF);
    send_beat(FN_CLEAR, 8'h00, 8'h00, 16'h0000);
    send_beat(FN_LOAD, 8'h00, 8'h00, 16'h0000);
    request_slice();
    send_beat(FN_LOAD, 8'hFF, 8'hFF, 16'hFFFF);
    send_beat(FN_LOAD, 8'hAA, 8'h07, 16'd5);
    send_beat(FN_LOAD, 8'h55, 8'h07, 16'd3);
    repeat (3) request_slice();
    for (int i = 0; i < 13; i++)
      send_beat(FN_LOAD, 8'(8'h10 + i), 8'($urandom_range(0, 255)), 16'($urandom_range(1, 9)));
    send_beat(FN_CLEAR, 8'h00, 8'h00, 16'h0000);

    for (int phase = 0; phase < N_PHASES; phase++) begin
      case (phase)
        0:       q = 16'd1;
        1:       q = 16'hFFFF;
        2:       q = 16'd0;
        default: q = ($urandom_range(99) < 70) ? 16'($urandom_range(1, 12)) : 16'($urandom);
      endcase
      write_quantum(q);
      calm = (phase == 3);
      if (phase == 1) begin
        send_beat(FN_CLEAR, 8'h00, 8'h00, 16'h0000);
        send_beat(FN_LOAD, 8'hFF, 8'h00, 16'hFFFF);
        request_slice();
      end
      phase_start = beats_sent;
      while (beats_sent - phase_start < PHASE_BEATS) begin
        run_sequence();
        if (phase == 5 && beats_sent - phase_start < 20) hold_req = 1'b1;
        if (phase == 7 && beats_sent - phase_start >= PHASE_BEATS / 2 &&
            beats_sent - phase_start < PHASE_BEATS / 2 + 12)
          pause_input();
      end
      calm = 1'b0;
    end

    pause_input();
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (mismatch_count == 0)
      $display("tb_priority_round_robin_scheduler: PASS");
    else
      $display("tb_priority_round_robin_scheduler: FAIL");
    $finish;
  end

endmodule
